// ----- hdl/dpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel colorizer package
// Shared types, status codes, fixed colors and register indexes.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Class reported with every result pixel.
  typedef enum logic [2:0] {
    CLS_MAPPED = 3'd0,
    CLS_ZERO   = 3'd1,
    CLS_RANGE  = 3'd2,
    CLS_SAT    = 3'd3,
    CLS_OVF    = 3'd4,
    CLS_INTF   = 3'd5,
    CLS_EDGE   = 3'd6
  } pix_class_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_STOP  = 2'd1,
    REG_COLOR_SCALE = 2'd2,
    REG_GRAY_SCALE  = 2'd3
  } cfg_reg_t;

  // What one colormap channel does at a given index.
  typedef enum logic [1:0] {
    MM_ZERO = 2'd0,
    MM_HOLD = 2'd1,
    MM_RAMP = 2'd2
  } map_mode_t;

  // Ramp width in colormap units (divisor is width times the step count).
  typedef enum logic [1:0] {
    DIV_W2 = 2'd0,
    DIV_W3 = 2'd1,
    DIV_W4 = 2'd2
  } div_sel_t;

  // Sensor status codes.
  localparam logic [15:0] CODE_OVERFLOW     = 16'd16002;
  localparam logic [15:0] CODE_SATURATION   = 16'd16003;
  localparam logic [15:0] CODE_INTERFERENCE = 16'd16007;
  localparam logic [15:0] CODE_EDGE         = 16'd16008;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t COLOR_SAT   = '{red: 8'd255, green: 8'd0,   blue: 8'd128};
  localparam rgb_t COLOR_OVF   = '{red: 8'd169, green: 8'd14,  blue: 8'd255};
  localparam rgb_t COLOR_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
  localparam rgb_t COLOR_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam rgb_t COLOR_GREY  = '{red: 8'd127, green: 8'd127, blue: 8'd127};

  // Configuration register set.
  typedef struct packed {
    logic [15:0] range_start;
    logic [15:0] range_stop;
    logic [31:0] color_scale;
    logic [31:0] gray_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    range_start: 16'd0,
    range_stop:  16'd7500,
    color_scale: 32'd65536,
    gray_scale:  32'd2228
  };

  // Per-pixel data that rides along the colormap pipeline.
  typedef struct packed {
    pix_class_t pixel_class;
    logic [7:0] gray;
  } side_t;

endpackage

// ----- hdl/dpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel colorizer front end
// Three stages: classify and offset, scale products, colormap index and gray.
// ----------------------------------------------------------------------------
module dpc_front
  import dpc_pkg::*;
#(
  parameter int COLOR_STEPS = 7500,
  localparam int IDX_W = $clog2(COLOR_STEPS)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      pixel_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_idx,
  output side_t            out_side
);

  localparam logic [31:0] STEPS = 32'(COLOR_STEPS);
  localparam logic [31:0] LAST  = 32'(COLOR_STEPS - 1);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // Stage 1 registers.
  logic [15:0] s1_dist;
  pix_class_t  s1_cls;
  // Stage 2 registers.
  logic [31:0] s2_p;
  logic [31:0] s2_g;
  pix_class_t  s2_cls;
  // Stage 3 registers.
  logic [IDX_W-1:0] s3_idx;
  side_t            s3_side;

  logic        below;
  logic [15:0] dist_next;
  pix_class_t  cls_next;
  logic [47:0] c_prod;
  logic [47:0] g_prod;
  logic [31:0] rev;
  logic [IDX_W-1:0] idx_next;
  logic [7:0]  gray_next;

  // A stage moves when it is empty or the next one moves.
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: offset from range start and status decode.
  always_comb begin
    below     = pixel_value < cfg.range_start;
    dist_next = below ? 16'd0 : pixel_value - cfg.range_start;
    if (pixel_value == CODE_SATURATION) begin
      cls_next = CLS_SAT;
    end else if (pixel_value == CODE_OVERFLOW) begin
      cls_next = CLS_OVF;
    end else if (pixel_value == CODE_INTERFERENCE) begin
      cls_next = CLS_INTF;
    end else if (pixel_value == CODE_EDGE) begin
      cls_next = CLS_EDGE;
    end else if (pixel_value == 16'd0) begin
      cls_next = CLS_ZERO;
    end else if (below || pixel_value > cfg.range_stop) begin
      cls_next = CLS_RANGE;
    end else begin
      cls_next = CLS_MAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_dist <= dist_next;
      s1_cls  <= cls_next;
    end
  end

  // Stage 2: Q16.16 scale products, integer part kept.
  assign c_prod = 48'(s1_dist) * 48'(cfg.color_scale);
  assign g_prod = 48'(s1_dist) * 48'(cfg.gray_scale);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_p   <= c_prod[47:16];
      s2_g   <= g_prod[47:16];
      s2_cls <= s1_cls;
    end
  end

  // Stage 3: reversed, clamped colormap index and saturated gray.
  assign rev = STEPS - s2_p;

  always_comb begin
    if (s2_cls == CLS_ZERO) begin
      idx_next = '0;
    end else if (s2_p == 32'd0) begin
      idx_next = LAST[IDX_W-1:0];
    end else if (s2_p >= STEPS) begin
      idx_next = '0;
    end else begin
      idx_next = rev[IDX_W-1:0];
    end
    gray_next = (s2_g > 32'd255) ? 8'hFF : s2_g[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_idx               <= idx_next;
      s3_side.pixel_class  <= s2_cls;
      s3_side.gray         <= gray_next;
    end
  end

  assign out_valid = v3;
  assign out_idx   = s3_idx;
  assign out_side  = s3_side;

  // A zero pixel always reads the first colormap entry.
  a_zero_idx: assert property (@(posedge clk) disable iff (rst)
    v3 && s3_side.pixel_class == CLS_ZERO |-> s3_idx == '0)
    else $error("zero pixel did not select colormap entry 0");

  // An accepted pixel occupies the first stage on the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted pixel lost at the first stage");

  // A mapped index never leaves the colormap.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> 32'(s3_idx) <= LAST)
    else $error("colormap index out of bounds");

endmodule

// ----- hdl/dpc_jet_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel colorizer jet colormap
// Evaluates the piecewise-linear jet map at an index in four stages, using a
// reciprocal multiply and one correction step for each channel's ramp.
// ----------------------------------------------------------------------------
module dpc_jet_map
  import dpc_pkg::*;
#(
  parameter int COLOR_STEPS = 7500,
  localparam int IDX_W = $clog2(COLOR_STEPS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_idx,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output rgb_t             out_rgb,
  output side_t            out_side
);

  // Widths: breakpoints reach 11 steps, ramp offsets reach 4 steps.
  localparam int CW  = IDX_W + 4;
  localparam int U_W = IDX_W + 3;
  localparam int X_W = U_W + 8;
  localparam int P_W = X_W + 32;

  localparam logic [CW-1:0] N1  = CW'(COLOR_STEPS);
  localparam logic [CW-1:0] N3  = CW'(3 * COLOR_STEPS);
  localparam logic [CW-1:0] N5  = CW'(5 * COLOR_STEPS);
  localparam logic [CW-1:0] N7  = CW'(7 * COLOR_STEPS);
  localparam logic [CW-1:0] N8  = CW'(8 * COLOR_STEPS);
  localparam logic [CW-1:0] N11 = CW'(11 * COLOR_STEPS);

  localparam logic [U_W-1:0] DEN2 = U_W'(2 * COLOR_STEPS);
  localparam logic [U_W-1:0] DEN3 = U_W'(3 * COLOR_STEPS);
  localparam logic [U_W-1:0] DEN4 = U_W'(4 * COLOR_STEPS);

  // floor(2^32 / divisor); the quotient estimate is low by at most one.
  localparam logic [31:0] RCP2 = 32'(64'h1_0000_0000 / 64'(2 * COLOR_STEPS));
  localparam logic [31:0] RCP3 = 32'(64'h1_0000_0000 / 64'(3 * COLOR_STEPS));
  localparam logic [31:0] RCP4 = 32'(64'h1_0000_0000 / 64'(4 * COLOR_STEPS));

  function automatic logic [31:0] rcp_of(div_sel_t s);
    case (s)
      DIV_W2:  rcp_of = RCP2;
      DIV_W3:  rcp_of = RCP3;
      DIV_W4:  rcp_of = RCP4;
      default: rcp_of = RCP2;
    endcase
  endfunction

  function automatic logic [U_W-1:0] den_of(div_sel_t s);
    case (s)
      DIV_W2:  den_of = DEN2;
      DIV_W3:  den_of = DEN3;
      DIV_W4:  den_of = DEN4;
      default: den_of = DEN2;
    endcase
  endfunction

  logic v4, v5, v6, v7;
  logic adv4, adv5, adv6, adv7;

  side_t s4_side, s5_side, s6_side, s7_side;

  logic [CW-1:0]  n8;
  map_mode_t      mode_next [3];
  div_sel_t       sel_next  [3];
  logic [U_W-1:0] u_next    [3];

  map_mode_t      s4_mode [3];
  div_sel_t       s4_sel  [3];
  logic [U_W-1:0] s4_u    [3];
  map_mode_t      s5_mode [3];
  div_sel_t       s5_sel  [3];
  logic [X_W-1:0] s5_x    [3];
  logic [P_W-1:0] s5_prod [3];
  map_mode_t      s6_mode [3];
  div_sel_t       s6_sel  [3];
  logic [X_W-1:0] s6_x    [3];
  logic [7:0]     s6_qest [3];
  logic [X_W-1:0] s6_qd   [3];
  logic [7:0]     s7_chan [3];
  logic [X_W-1:0] rem     [3];
  logic [X_W-1:0] den6    [3];

  // Stage handshake: a stage moves when it is empty or the next one moves.
  assign adv7     = !v7 || out_ready;
  assign adv6     = !v6 || adv7;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign in_ready = adv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (adv4) v4 <= in_valid;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
    end
  end

  // Stage 4: locate each channel's piece at x = 8k/N and its ramp offset.
  assign n8 = CW'({in_idx, 3'b000});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mode_next[c] = MM_ZERO;
      sel_next[c]  = DIV_W2;
      u_next[c]    = '0;
    end
    // Red: rises on [3,5), holds on [5,7), falls on [7,11).
    if (n8 >= N3 && n8 < N5) begin
      mode_next[0] = MM_RAMP;
      u_next[0]    = U_W'(n8 - N3);
    end else if (n8 >= N5 && n8 < N7) begin
      mode_next[0] = MM_HOLD;
    end else if (n8 >= N7 && n8 < N11) begin
      mode_next[0] = MM_RAMP;
      sel_next[0]  = DIV_W4;
      u_next[0]    = U_W'(N11 - n8);
    end
    // Green: rises on [1,3), holds on [3,5), falls on [5,8).
    if (n8 >= N1 && n8 < N3) begin
      mode_next[1] = MM_RAMP;
      u_next[1]    = U_W'(n8 - N1);
    end else if (n8 >= N3 && n8 < N5) begin
      mode_next[1] = MM_HOLD;
    end else if (n8 >= N5 && n8 < N8) begin
      mode_next[1] = MM_RAMP;
      sel_next[1]  = DIV_W3;
      u_next[1]    = U_W'(N8 - n8);
    end
    // Blue: rises from half on [0,1), holds on [1,3), falls on [3,5).
    if (n8 < N1) begin
      mode_next[2] = MM_RAMP;
      u_next[2]    = U_W'(n8 + N1);
    end else if (n8 < N3) begin
      mode_next[2] = MM_HOLD;
    end else if (n8 < N5) begin
      mode_next[2] = MM_RAMP;
      u_next[2]    = U_W'(N5 - n8);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_side <= in_side;
      s4_mode <= mode_next;
      s4_sel  <= sel_next;
      s4_u    <= u_next;
    end
  end

  // Sideband follows the channel lanes.
  always_ff @(posedge clk) begin
    if (adv5) s5_side <= s4_side;
    if (adv6) s6_side <= s5_side;
    if (adv7) s7_side <= s6_side;
  end

  // Stages 5 to 7, one lane per channel: floor(u * 255 / divisor).
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [X_W-1:0] x_next;
    logic [7:0]     qest_next;
    logic [7:0]     q_fix;

    // Stage 5: numerator and reciprocal product.
    assign x_next = (X_W'(s4_u[c]) << 8) - X_W'(s4_u[c]);

    always_ff @(posedge clk) begin
      if (adv5) begin
        s5_mode[c] <= s4_mode[c];
        s5_sel[c]  <= s4_sel[c];
        s5_x[c]    <= x_next;
        s5_prod[c] <= P_W'(x_next) * P_W'(rcp_of(s4_sel[c]));
      end
    end

    // Stage 6: quotient estimate and its back product.
    assign qest_next = s5_prod[c][39:32];

    always_ff @(posedge clk) begin
      if (adv6) begin
        s6_mode[c] <= s5_mode[c];
        s6_sel[c]  <= s5_sel[c];
        s6_x[c]    <= s5_x[c];
        s6_qest[c] <= qest_next;
        s6_qd[c]   <= X_W'(X_W'(qest_next) * X_W'(den_of(s5_sel[c])));
      end
    end

    // Stage 7: one correction step, then the channel value.
    assign den6[c] = X_W'(den_of(s6_sel[c]));
    assign rem[c]  = s6_x[c] - s6_qd[c];
    assign q_fix   = (rem[c] >= den6[c]) ? s6_qest[c] + 8'd1 : s6_qest[c];

    always_ff @(posedge clk) begin
      if (adv7) begin
        case (s6_mode[c])
          MM_ZERO: s7_chan[c] <= 8'd0;
          MM_HOLD: s7_chan[c] <= 8'd255;
          MM_RAMP: s7_chan[c] <= q_fix;
          default: s7_chan[c] <= 8'd0;
        endcase
      end
    end
  end

  assign out_valid = v7;
  assign out_rgb   = '{red: s7_chan[0], green: s7_chan[1], blue: s7_chan[2]};
  assign out_side  = s7_side;

  // The reciprocal estimate is never more than one below the quotient.
  for (genvar a = 0; a < 3; a++) begin : g_chk
    a_rem_bound: assert property (@(posedge clk) disable iff (rst)
      v6 && s6_mode[a] == MM_RAMP |-> rem[a] < (den6[a] << 1))
      else $error("ramp quotient estimate off by more than one");
  end

  // A request taken at the input reaches the first map stage.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v4)
    else $error("index lost entering the colormap pipeline");

  // A stalled last stage keeps its sideband.
  a_hold_side: assert property (@(posedge clk) disable iff (rst)
    v7 && !out_ready |=> v7 && $stable(s7_side))
    else $error("colormap result changed while stalled");

endmodule

// ----- hdl/depth_pixel_colorizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel colorizer
// Turns time-of-flight distance pixels into jet-colored RGB plus gray.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 16-bit distance pixel per request. m_axis returns one
//   result per pixel: red, green, blue and gray in tdata and the pixel class
//   in tuser. The cfg channel writes the range start and stop and the two
//   Q16.16 scales; it is always ready and should be used only while no pixel
//   is in flight.
//   Each pixel passes the front-end, colormap and output registers. The
//   block takes one pixel per clock while m_axis_tready is high; the depth
//   comes from the scale multipliers and the per-channel reciprocal divides.
//   Reset clears every stage valid and loads the default register values:
//   start 0, stop 7500, color scale 1.0, gray scale 2228/65536.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling until all eight are full; only then does
//   s_axis_tready drop. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module depth_pixel_colorizer_top
  import dpc_pkg::*;
#(
  parameter int COLOR_STEPS = 7500
) (
  input  logic        clk,
  input  logic        rst,
  // Pixel input. tdata: pixel_value[15:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // Result output. tdata: red[7:0], green[15:8], blue[23:16], gray[31:24].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // tuser: pixel_class[2:0].
  output logic [2:0]  m_axis_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(COLOR_STEPS);

  cfg_t             cfg_q;
  logic             fe_valid;
  logic             fe_ready;
  logic [IDX_W-1:0] fe_idx;
  side_t            fe_side;
  logic             map_valid;
  logic             map_ready;
  rgb_t             map_rgb;
  side_t            map_side;

  logic  out_vld;
  rgb_t  out_rgb;
  side_t out_side;
  rgb_t  rgb_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_START: cfg_q.range_start <= cfg_data[15:0];
        REG_RANGE_STOP:  cfg_q.range_stop  <= cfg_data[15:0];
        REG_COLOR_SCALE: cfg_q.color_scale <= cfg_data;
        REG_GRAY_SCALE:  cfg_q.gray_scale  <= cfg_data;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  dpc_front #(
    .COLOR_STEPS(COLOR_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pixel_value(s_axis_tdata),
    .out_valid  (fe_valid),
    .out_ready  (fe_ready),
    .out_idx    (fe_idx),
    .out_side   (fe_side)
  );

  dpc_jet_map #(
    .COLOR_STEPS(COLOR_STEPS)
  ) u_jet_map (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fe_valid),
    .in_ready (fe_ready),
    .in_idx   (fe_idx),
    .in_side  (fe_side),
    .out_valid(map_valid),
    .out_ready(map_ready),
    .out_rgb  (map_rgb),
    .out_side (map_side)
  );

  // Final color: status codes and out-of-range pixels override the map.
  always_comb begin
    case (map_side.pixel_class)
      CLS_MAPPED: rgb_next = map_rgb;
      CLS_ZERO:   rgb_next = map_rgb;
      CLS_RANGE:  rgb_next = COLOR_GREY;
      CLS_SAT:    rgb_next = COLOR_SAT;
      CLS_OVF:    rgb_next = COLOR_OVF;
      CLS_INTF:   rgb_next = COLOR_WHITE;
      CLS_EDGE:   rgb_next = COLOR_BLACK;
      default:    rgb_next = COLOR_BLACK;
    endcase
  end

  // Output register.
  assign map_ready = !out_vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (map_ready) begin
      out_vld <= map_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (map_ready) begin
      out_rgb  <= rgb_next;
      out_side <= map_side;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_side.gray, out_rgb.blue, out_rgb.green, out_rgb.red};
  assign m_axis_tuser  = out_side.pixel_class;

  // Out-of-range pixels come out flat grey.
  a_range_grey: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_side.pixel_class == CLS_RANGE |-> out_rgb == COLOR_GREY)
    else $error("out-of-range pixel not grey");

  // Saturated pixels come out in the saturation color.
  a_sat_color: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_side.pixel_class == CLS_SAT |-> out_rgb == COLOR_SAT)
    else $error("saturation pixel has wrong color");

  // A range stop write lands in the register set.
  a_cfg_stop: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_RANGE_STOP
    |=> cfg_q.range_stop == $past(cfg_data[15:0]))
    else $error("range stop write not taken");

endmodule
